>>> rtl/lcdns_pkg.sv
// ----------------------------------------------------------------------------
// lcdns_pkg
// shared types, request codes and the power-up pulse table for the
// character lcd nibble sequencer
// ----------------------------------------------------------------------------
package lcdns_pkg;

  localparam int LINE_OFFSET_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 4;

  // request kinds on req_type
  localparam logic [2:0] REQ_INIT   = 3'd0;
  localparam logic [2:0] REQ_DATA   = 3'd1;
  localparam logic [2:0] REQ_CMD    = 3'd2;
  localparam logic [2:0] REQ_CURSOR = 3'd3;
  localparam logic [2:0] REQ_NUMBER = 3'd4;

  localparam logic [7:0] CURSOR_CMD = 8'h80;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // index of the final pulse of each job kind
  localparam logic [3:0] INIT_LAST = 4'd15;
  localparam logic [3:0] BYTE_LAST = 4'd1;
  localparam logic [3:0] NUM_LAST  = 4'd5;

  typedef enum logic [1:0] {
    JOB_INIT,
    JOB_DATA,
    JOB_CMD,
    JOB_NUM
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] value;
    logic [3:0] hund;
    logic [6:0] rest;
  } job_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       reg_select;
    logic [4:0] wait_before_ms;
    logic [2:0] wait_after_ms;
    logic       last_pulse;
  } pulse_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic       busy;
    job_kind_t  kind;
    logic [3:0] step;
  } back_status_t;

  // power-up run: three wake-up nibbles, 4-bit switch, then six commands
  function automatic pulse_t init_pulse(input logic [3:0] step);
    pulse_t p;
    p = '0;
    p.wait_after_ms = 3'd1;
    unique case (step)
      4'd0: begin
        p.nibble         = 4'h3;
        p.wait_before_ms = 5'd20;
        p.wait_after_ms  = 3'd5;
      end
      4'd1:  p.nibble = 4'h3;
      4'd2:  p.nibble = 4'h3;
      4'd3:  p.nibble = 4'h2;
      4'd4:  p.nibble = 4'h2;
      4'd5:  p.nibble = 4'h8;
      4'd6:  p.nibble = 4'h0;
      4'd7:  p.nibble = 4'h8;
      4'd8:  p.nibble = 4'h0;
      4'd9: begin
        p.nibble        = 4'h1;
        p.wait_after_ms = 3'd3;
      end
      4'd10: p.nibble = 4'h0;
      4'd11: p.nibble = 4'h6;
      4'd12: p.nibble = 4'h1;
      4'd13: p.nibble = 4'h4;
      4'd14: p.nibble = 4'h0;
      default: begin
        p.nibble        = 4'hF;
        p.wait_after_ms = 3'd3;
      end
    endcase
    return p;
  endfunction

endpackage

>>> rtl/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// turns lcd requests into the run of 4-bit enable pulses of a character lcd
// ----------------------------------------------------------------------------
// Push one request item per cycle while full is low; each accepted request
// gives its enable pulses as result items, one per cycle, while pop keeps up.
// Init gives 16 pulses, data, command and cursor requests give 2, a number
// gives 6; kinds 5 to 7 are taken and dropped. The pulse sequencer emits one
// pulse per clock while pop keeps up, so a request holds the output side until
// all of its pulses are out (16 at most, for init), and the job queue (QUEUE_DEPTH
// entries) lets new requests be taken meanwhile. The first pulse of a request
// passes through the queue, the job registers and the result register before it
// shows on the result ports, and a queued next job starts in the cycle after the
// last pulse of the one before.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer import lcdns_pkg::*; #(
  parameter int LINE_OFFSET = LINE_OFFSET_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // request side
  input  logic       push,
  output logic       full,
  input  logic [2:0] req_type,
  input  logic [7:0] data_byte,
  input  logic [1:0] row,
  input  logic [5:0] column,
  input  logic [9:0] number,
  // pulse side
  output logic       empty,
  input  logic       pop,
  output logic [3:0] nibble,
  output logic       reg_select,
  output logic [4:0] wait_before_ms,
  output logic [2:0] wait_after_ms,
  output logic       last_pulse
);

  logic          job_valid;
  job_t          front_job;
  job_t          head_job;
  logic          q_pop;
  queue_status_t q_stat;
  logic          out_valid;
  pulse_t        out_pulse;
  back_status_t  bk_stat;

  // front: decode kind, cursor address and hundreds digit
  lcdns_front #(
    .LINE_OFFSET(LINE_OFFSET)
  ) u_front (
    .req_type (req_type),
    .data_byte(data_byte),
    .row      (row),
    .column   (column),
    .number   (number),
    .job_valid(job_valid),
    .job      (front_job)
  );

  // unknown kinds are accepted but never queued
  lcdns_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr_en (push && job_valid),
    .wr_job(front_job),
    .rd_en (q_pop),
    .rd_job(head_job),
    .status(q_stat)
  );

  // back: pulse sequencer with the result register
  lcdns_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_stat.empty),
    .head     (head_job),
    .q_pop    (q_pop),
    .out_pop  (pop),
    .out_valid(out_valid),
    .out_pulse(out_pulse),
    .status   (bk_stat)
  );

  assign full           = q_stat.full;
  assign empty          = !out_valid;
  assign nibble         = out_pulse.nibble;
  assign reg_select     = out_pulse.reg_select;
  assign wait_before_ms = out_pulse.wait_before_ms;
  assign wait_after_ms  = out_pulse.wait_after_ms;
  assign last_pulse     = out_pulse.last_pulse;

`ifndef SYNTHESIS
  // a waiting pulse that is not the last one means its job is still running
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !last_pulse) |-> bk_stat.busy)
    else $error("non-final pulse waiting with sequencer idle");

  // a queued request is never lost between front and back
  assert property (@(posedge clk) disable iff (rst)
    (push && !full && (req_type == REQ_INIT || req_type == REQ_DATA ||
     req_type == REQ_CMD || req_type == REQ_CURSOR || req_type == REQ_NUMBER))
    |=> (!q_stat.empty || bk_stat.busy))
    else $error("accepted request vanished");

  // only init runs past the sixth pulse
  assert property (@(posedge clk) disable iff (rst)
    (bk_stat.busy && bk_stat.kind != JOB_INIT) |-> (bk_stat.step <= NUM_LAST))
    else $error("pulse step beyond end of job");
`endif

endmodule

>>> rtl/lcdns_front.sv
// ----------------------------------------------------------------------------
// lcdns_front
// classifies a request into a job and precomputes its byte or hundreds digit
// ----------------------------------------------------------------------------
module lcdns_front import lcdns_pkg::*; #(
  parameter int LINE_OFFSET = LINE_OFFSET_DEF
) (
  input  logic [2:0] req_type,
  input  logic [7:0] data_byte,
  input  logic [1:0] row,
  input  logic [5:0] column,
  input  logic [9:0] number,
  output logic       job_valid,
  output job_t       job
);

  logic [7:0]  col_m1;
  logic [7:0]  row_m1;
  logic [15:0] row_prod;
  logic [7:0]  cursor_pos;
  logic [3:0]  hund;
  logic [9:0]  hund_x100;
  logic [9:0]  rest_w;

  always_comb begin
    col_m1     = {2'b00, column} - 8'd1;
    row_m1     = {6'b000000, row} - 8'd1;
    row_prod   = 16'(row_m1) * 16'(LINE_OFFSET);
    cursor_pos = (col_m1 + row_prod[7:0]) | CURSOR_CMD;
  end

  // hundreds digit by threshold compare, up to 10 for values above 999
  always_comb begin
    hund      = 4'd0;
    hund_x100 = 10'd0;
    for (int i = 1; i <= 10; i++) begin
      if (number >= 10'(i * 100)) begin
        hund      = 4'(i);
        hund_x100 = 10'(i * 100);
      end
    end
    rest_w = number - hund_x100;
  end

  always_comb begin
    job_valid = 1'b1;
    job.kind  = JOB_INIT;
    job.value = data_byte;
    job.hund  = hund;
    job.rest  = rest_w[6:0];
    unique case (req_type)
      REQ_INIT:   job.kind = JOB_INIT;
      REQ_DATA:   job.kind = JOB_DATA;
      REQ_CMD:    job.kind = JOB_CMD;
      REQ_CURSOR: begin
        job.kind  = JOB_CMD;
        job.value = cursor_pos;
      end
      REQ_NUMBER: job.kind = JOB_NUM;
      default:    job_valid = 1'b0;
    endcase
  end

endmodule

>>> rtl/lcdns_queue.sv
// ----------------------------------------------------------------------------
// lcdns_queue
// short job queue between the front and the pulse sequencer
// ----------------------------------------------------------------------------
module lcdns_queue import lcdns_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  job_t          wr_job,
  input  logic          rd_en,
  output job_t          rd_job,
  output queue_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_wr        = wr_en && !status.full;
  assign do_rd        = rd_en && !status.empty;
  assign rd_job       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

>>> rtl/lcdns_back.sv
// ----------------------------------------------------------------------------
// lcdns_back
// steps through the pulses of the current job into the result register, one
// per cycle while that register is empty or being popped
// ----------------------------------------------------------------------------
module lcdns_back import lcdns_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_empty,
  input  job_t         head,
  output logic         q_pop,
  input  logic         out_pop,
  output logic         out_valid,
  output pulse_t       out_pulse,
  output back_status_t status
);

  logic       busy;
  job_kind_t  kind;
  logic [3:0] step;
  logic [7:0] cur_bytes [3];

  logic [3:0] last_idx;
  logic       at_last;
  logic       can_emit;
  logic       take;
  logic [7:0] sel_byte;
  pulse_t     pulse;
  logic [6:0] tens;
  logic [6:0] tens_x10;
  logic [6:0] units;

  always_comb begin
    unique case (kind)
      JOB_INIT: last_idx = INIT_LAST;
      JOB_NUM:  last_idx = NUM_LAST;
      default:  last_idx = BYTE_LAST;
    endcase
  end

  assign at_last  = (step == last_idx);
  assign can_emit = busy && (!out_valid || out_pop);
  assign take     = !q_empty && (!busy || (can_emit && at_last));
  assign q_pop    = take;

  always_comb begin
    unique case (step[2:1])
      2'd0:    sel_byte = cur_bytes[0];
      2'd1:    sel_byte = cur_bytes[1];
      default: sel_byte = cur_bytes[2];
    endcase
  end

  always_comb begin
    if (kind == JOB_INIT) begin
      pulse = init_pulse(step);
    end else begin
      pulse                = '0;
      pulse.nibble         = step[0] ? sel_byte[3:0] : sel_byte[7:4];
      pulse.reg_select     = (kind == JOB_DATA) || (kind == JOB_NUM);
      pulse.wait_after_ms  = 3'd1;
    end
    pulse.last_pulse = at_last;
  end

  // tens and units of the remainder below one hundred
  always_comb begin
    tens     = 7'd0;
    tens_x10 = 7'd0;
    for (int i = 1; i <= 9; i++) begin
      if (head.rest >= 7'(i * 10)) begin
        tens     = 7'(i);
        tens_x10 = 7'(i * 10);
      end
    end
    units = head.rest - tens_x10;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      kind      <= JOB_INIT;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (can_emit) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        busy <= 1'b1;
        kind <= head.kind;
        step <= '0;
      end else if (can_emit) begin
        step <= step + 4'd1;
        if (at_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit) begin
      out_pulse <= pulse;
    end
    if (take) begin
      if (head.kind == JOB_NUM) begin
        cur_bytes[0] <= {4'b0000, head.hund} + ASCII_ZERO;
        cur_bytes[1] <= {1'b0, tens} + ASCII_ZERO;
        cur_bytes[2] <= {1'b0, units} + ASCII_ZERO;
      end else begin
        cur_bytes[0] <= head.value;
        cur_bytes[1] <= head.value;
        cur_bytes[2] <= head.value;
      end
    end
  end

  assign status.busy = busy;
  assign status.kind = kind;
  assign status.step = step;

endmodule
